### rtl/ppsg_pkg.sv
// Shared types, sizes and the ordering function for the odd/even partition sorter.
// No dependencies; every other file refers to this package by scoped names.
package ppsg_pkg;

   localparam int MAX_ITEMS   = 16;
   localparam int VALUE_BITS  = 16;
   localparam int FIELD_BITS  = 16;
   localparam int COUNT_BITS  = $clog2(MAX_ITEMS + 1);
   localparam int SHIFT_BITS  = $clog2(VALUE_BITS + 1);

   typedef struct packed {
      logic                  valid;
      logic [VALUE_BITS-1:0] value;
   } slot_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_DRAIN,
      ST_START,
      ST_CALC
   } state_type;

   // Odd values sort ahead of even ones, then ascending value.
   function automatic logic goes_after(input logic [VALUE_BITS-1:0] a,
                                       input logic [VALUE_BITS-1:0] b);
      logic [VALUE_BITS:0] key_a;
      logic [VALUE_BITS:0] key_b;
      key_a = {~a[0], a};
      key_b = {~b[0], b};
      return key_a > key_b;
   endfunction

endpackage

### rtl/ppsg_cell.sv
// One cell of the insertion chain: holds one batch element, passes the one that sorts later right.
// In shift mode the cell takes its right neighbor's element. Uses ppsg_pkg.
module ppsg_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  ppsg_pkg::slot_type left_in,
   input  ppsg_pkg::slot_type right_in,
   output ppsg_pkg::slot_type held,
   output ppsg_pkg::slot_type pass
);

   ppsg_pkg::slot_type held_ff, held_in;
   ppsg_pkg::slot_type pass_ff, pass_in;

   always_comb begin
      held_in = held_ff;
      pass_in = '0;
      if (shift_en) begin
         held_in = right_in;
      end else if (left_in.valid) begin
         if (!held_ff.valid) begin
            held_in = left_in;
         end else if (ppsg_pkg::goes_after(held_ff.value, left_in.value)) begin
            // keep the newcomer, push the held element onward
            held_in = left_in;
            pass_in = held_ff;
         end else begin
            pass_in = left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff.valid <= 1'b0;
         pass_ff.valid <= 1'b0;
      end else begin
         held_ff.valid <= held_in.valid;
         pass_ff.valid <= pass_in.valid;
      end
      held_ff.value <= held_in.value;
      pass_ff.value <= pass_in.value;
   end

   assign held = held_ff;
   assign pass = pass_ff;

endmodule

### rtl/ppsg_gcd.sv
// Iterative binary divisor unit: one halving or subtract step per cycle.
// Either operand zero gives zero. Uses ppsg_pkg.
module ppsg_gcd (
   input  logic                            clock,
   input  logic                            start,
   input  logic [ppsg_pkg::VALUE_BITS-1:0] a_op,
   input  logic [ppsg_pkg::VALUE_BITS-1:0] b_op,
   output logic                            done,
   output logic [ppsg_pkg::VALUE_BITS-1:0] result
);

   logic [ppsg_pkg::VALUE_BITS-1:0] a_ff, a_in;
   logic [ppsg_pkg::VALUE_BITS-1:0] b_ff, b_in;
   logic [ppsg_pkg::SHIFT_BITS-1:0] k_ff, k_in;

   assign done   = (a_ff == '0) || (b_ff == '0);
   assign result = (a_ff | b_ff) << k_ff;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      k_in = k_ff;
      if (start) begin
         k_in = '0;
         if ((a_op == '0) || (b_op == '0)) begin
            a_in = '0;
            b_in = '0;
         end else begin
            a_in = a_op;
            b_in = b_op;
         end
      end else if (!done) begin
         priority if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_in = a_ff - b_ff;
         end else begin
            b_in = b_ff - a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      k_ff <= k_in;
   end

endmodule

### rtl/parity_partitioned_sort_gcd_core.sv
// Odd/even partition sorter with neighbor divisors, top level.
// Instantiates ppsg_cell (insertion chain) and ppsg_gcd; uses ppsg_pkg.
//
// Usage:
//   req_ carries one element per beat (tdata = value, tlast ends the batch).
//   A batch also ends at its MAX_ITEMS-th beat. While loading, one beat is
//   taken per cycle; each beat enters cell 0 and ripples right through the
//   chain, one cell per cycle, so the chain always holds the batch in order.
//   After the batch ends, req_tready stays low: the chain settles, then
//   results leave from cell 0, odds ascending, then evens ascending. Each
//   result needs a start state, the divisor unit's steps (none when an
//   operand is zero, otherwise one halving or subtract per cycle) and its
//   release, and the drain also waits on any receiver stalls. rsp_ beats
//   carry tdata = {gcd_next, sorted_value}, tlast = end_of_batch.
//   The result sits in an output register; a stalled receiver holds it and
//   the next divisor is computed meanwhile but not released.
//   Reset empties the chain and returns to loading with no result pending.
module parity_partitioned_sort_gcd_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] sorted_value, [31:16] gcd_next
   output logic        rsp_tlast
);

   localparam int N  = ppsg_pkg::MAX_ITEMS;
   localparam int VB = ppsg_pkg::VALUE_BITS;
   localparam int FB = ppsg_pkg::FIELD_BITS;
   localparam int CB = ppsg_pkg::COUNT_BITS;

   ppsg_pkg::state_type state_ff, state_in;
   logic [CB-1:0]       count_ff, count_in;

   ppsg_pkg::slot_type held [N];
   ppsg_pkg::slot_type pass [N];
   ppsg_pkg::slot_type left_src [N];
   ppsg_pkg::slot_type right_src [N];
   logic [N-1:0]        pass_busy;

   logic          accept;
   logic          batch_end;
   logic          shift_en;
   logic          gcd_start;
   logic          gcd_done;
   logic [VB-1:0] gcd_result;
   logic          fire;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [FB-1:0] rsp_value_ff, rsp_value_in;
   logic [FB-1:0] rsp_gcd_ff, rsp_gcd_in;
   logic          rsp_last_ff, rsp_last_in;

   assign accept    = req_tvalid && req_tready;
   assign batch_end = req_tlast || (count_ff == CB'(N - 1));
   assign fire      = (state_ff == ppsg_pkg::ST_CALC) && gcd_done &&
                      (!rsp_valid_ff || rsp_tready);

   // chain wiring
   always_comb begin
      for (int i = 0; i < N; i++) begin
         pass_busy[i] = pass[i].valid;
         if (i == 0) begin
            left_src[i].valid = accept;
            left_src[i].value = req_tdata[VB-1:0];
         end else begin
            left_src[i] = pass[i-1];
         end
         if (i == N - 1) begin
            right_src[i] = '0;
         end else begin
            right_src[i] = held[i+1];
         end
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_cell
      ppsg_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .left_in  (left_src[g]),
         .right_in (right_src[g]),
         .held     (held[g]),
         .pass     (pass[g])
      );
   end

   ppsg_gcd u_gcd (
      .clock  (clock),
      .start  (gcd_start),
      .a_op   (held[0].value),
      .b_op   (held[1].valid ? held[1].value : '0),
      .done   (gcd_done),
      .result (gcd_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppsg_pkg::ST_LOAD:  if (accept && batch_end) state_in = ppsg_pkg::ST_DRAIN;
         ppsg_pkg::ST_DRAIN: if (pass_busy == '0) state_in = ppsg_pkg::ST_START;
         ppsg_pkg::ST_START: state_in = ppsg_pkg::ST_CALC;
         ppsg_pkg::ST_CALC: begin
            if (fire) begin
               state_in = held[1].valid ? ppsg_pkg::ST_START : ppsg_pkg::ST_LOAD;
            end
         end
         default: state_in = ppsg_pkg::ST_LOAD;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      gcd_start  = 1'b0;
      shift_en   = 1'b0;
      unique case (state_ff)
         ppsg_pkg::ST_LOAD:  req_tready = 1'b1;
         ppsg_pkg::ST_DRAIN: ;
         ppsg_pkg::ST_START: gcd_start = 1'b1;
         ppsg_pkg::ST_CALC:  shift_en = fire;
         default: ;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = batch_end ? '0 : count_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_gcd_in   = rsp_gcd_ff;
      rsp_last_in  = rsp_last_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = FB'(held[0].value);
         rsp_gcd_in   = FB'(gcd_result);
         rsp_last_in  = !held[1].valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppsg_pkg::ST_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_gcd_ff   <= rsp_gcd_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_gcd_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

### verif/tb_parity_partitioned_sort_gcd_core.sv
// Self-checking bench for parity_partitioned_sort_gcd_core: batches of elements go in on req_,
// each rsp_ beat is checked against an in-bench odd/even sort and neighbor divisor predictor.
// Depends on rtl/ppsg_pkg.sv and rtl/parity_partitioned_sort_gcd_core.sv.
module tb_parity_partitioned_sort_gcd_core;

   localparam int IDLE_PERCENT  = 22;
   localparam int CALM_FROM     = 2000;
   localparam int CALM_TO       = 5000;
   localparam int RANDOM_ITEMS  = 280;
   localparam int SETTLE_CYCLES = 4 * (2 * ppsg_pkg::VALUE_BITS + 3);
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;

   typedef logic [ppsg_pkg::VALUE_BITS-1:0] elem_type;

   typedef struct {
      elem_type value;
      logic     last;
      bit       hold;   // wait for every outstanding result before sending
   } element_beat_type;

   typedef struct {
      logic [15:0] sorted_value;
      logic [15:0] gcd_next;
      logic        end_of_batch;
   } sorted_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [15:0] value
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [15:0] sorted_value, [31:16] gcd_next
   logic        rsp_tlast;

   element_beat_type pending_beats[$];
   sorted_entry_type sorted_results[$];
   elem_type         open_batch[$];
   int               mismatches = 0;
   int               cycle_count = 0;
   bit               drained = 1'b1;
   bit               pause_armed = 1'b0;

   parity_partitioned_sort_gcd_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic bit take_gap();
      if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) return 1'b0;
      return $urandom_range(0, 99) < IDLE_PERCENT;
   endfunction

   // a goes behind b: evens behind odds, then larger behind smaller
   function automatic bit sorts_after(elem_type a, elem_type b);
      if (a[0] != b[0]) return b[0];
      return a > b;
   endfunction

   function automatic logic [15:0] neighbor_gcd(elem_type a, elem_type b);
      elem_type x;
      elem_type y;
      elem_type r;
      x = a;
      y = b;
      if (x == '0 || y == '0) return '0;
      while (y != '0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   task automatic collect_element(elem_type v, logic last);
      elem_type         t;
      sorted_entry_type e;
      int               n;
      open_batch.push_back(v);
      if (!last && open_batch.size() < ppsg_pkg::MAX_ITEMS) return;
      n = open_batch.size();
      for (int i = 1; i < n; i++) begin
         for (int j = 0; j + i < n; j++) begin
            if (sorts_after(open_batch[j], open_batch[j+1])) begin
               t = open_batch[j];
               open_batch[j] = open_batch[j+1];
               open_batch[j+1] = t;
            end
         end
      end
      for (int k = 0; k < n; k++) begin
         e.sorted_value = open_batch[k];
         e.gcd_next     = (k + 1 < n) ? neighbor_gcd(open_batch[k], open_batch[k+1]) : '0;
         e.end_of_batch = (k + 1 == n);
         sorted_results.push_back(e);
      end
      open_batch.delete();
   endtask

   task automatic check_result(logic [31:0] data, logic tlast);
      sorted_entry_type e;
      if (sorted_results.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("unexpected result: value %0d gcd %0d last %0b",
                     data[15:0], data[31:16], tlast);
         return;
      end
      e = sorted_results.pop_front();
      if (data[15:0] !== e.sorted_value || data[31:16] !== e.gcd_next ||
          tlast !== e.end_of_batch) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("mismatch: value %0d/%0d gcd %0d/%0d last %0b/%0b (exp/got)",
                     e.sorted_value, data[15:0], e.gcd_next, data[31:16],
                     e.end_of_batch, tlast);
      end
   endtask

   task automatic add_beat(elem_type v, logic last, bit hold);
      element_beat_type b;
      b.value = v;
      b.last  = last;
      b.hold  = hold;
      pending_beats.push_back(b);
   endtask

   function automatic elem_type value_pick(int style);
      int factor;
      case (style)
         0: return elem_type'($urandom_range(0, 65535));
         1: return elem_type'($urandom_range(0, 48));
         2: begin
            factor = $urandom_range(1, 700);
            return elem_type'(factor * $urandom_range(0, 65535 / factor));
         end
         default: begin
            case ($urandom_range(0, 4))
               0: return '0;
               1: return elem_type'(1);
               2: return '1;
               3: return elem_type'(16'hFFFE);
               default: return elem_type'($urandom_range(0, 65535));
            endcase
         end
      endcase
   endfunction

   // driver: present the next pending beat when the slot is free, unless a random gap or a hold intervenes
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid  <= 1'b0;
         req_tdata   <= '0;
         req_tlast   <= 1'b0;
         pause_armed <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_beats.size() == 0 || take_gap()) begin
            req_tvalid <= 1'b0;
         end else if (pending_beats[0].hold && !pause_armed) begin
            // drop valid first so drained reflects the last accepted beat
            req_tvalid  <= 1'b0;
            pause_armed <= 1'b1;
         end else if (pending_beats[0].hold && !drained) begin
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid  <= 1'b1;
            req_tdata   <= pending_beats[0].value;
            req_tlast   <= pending_beats[0].last;
            pause_armed <= 1'b0;
            void'(pending_beats.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && !take_gap();
   end

   // monitor: check result beats, then fold accepted elements into the predictor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) collect_element(req_tdata, req_tlast);
      end
      drained <= (sorted_results.size() == 0);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int       sent;
      int       len;
      int       style;
      logic     last;
      elem_type full_batch[16];

      // single element: final result carries a zero divisor
      add_beat('1, 1'b1, 1'b0);
      // zero operands
      add_beat('0, 1'b0, 1'b0);
      add_beat(elem_type'(6), 1'b0, 1'b0);
      add_beat(elem_type'(4), 1'b1, 1'b0);
      // equal values among the odds, mixed with evens
      add_beat(elem_type'(12), 1'b0, 1'b0);
      add_beat(elem_type'(18), 1'b0, 1'b0);
      add_beat(elem_type'(7), 1'b0, 1'b0);
      add_beat(elem_type'(21), 1'b0, 1'b0);
      add_beat(elem_type'(7), 1'b1, 1'b0);
      // full store closes the batch without tlast
      full_batch = '{16'hFFFF, 16'hFFFE, 16'h0001, 16'h0002, 16'h8000, 16'h7FFF,
                     16'h0003, 16'h0009, 16'h000F, 16'h000A, 16'h0014, 16'h0005,
                     16'h0005, 16'h9C40, 16'h03FF, 16'h5555};
      foreach (full_batch[i]) add_beat(full_batch[i], 1'b0, 1'b0);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         len   = ($urandom_range(0, 5) == 0) ? ppsg_pkg::MAX_ITEMS
                                             : $urandom_range(1, ppsg_pkg::MAX_ITEMS);
         style = $urandom_range(0, 3);
         for (int k = 0; k < len; k++) begin
            last = (k == len - 1) &&
                   (len < ppsg_pkg::MAX_ITEMS || $urandom_range(0, 1) == 1);
            // hold off the first random batch until the directed results are out
            add_beat(value_pick(style), last, sent == 0);
            sent++;
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_beats.size() != 0 || req_tvalid || !drained) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (sorted_results.size() != 0)
         $display("%0d expected results never arrived", sorted_results.size());
      if (mismatches == 0 && sorted_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/ppsg_pkg.sv
rtl/ppsg_cell.sv
rtl/ppsg_gcd.sv
rtl/parity_partitioned_sort_gcd_core.sv
verif/tb_parity_partitioned_sort_gcd_core.sv
